@@ src/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and fixed field widths for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int VALUE_W  = 32;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;
	localparam int ECOUNT_W = 5;

	// Request kinds; the two remaining codes are ignored.
	typedef enum logic [REQ_W-1:0] {
		REQ_LIST       = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_PUSH_REAR  = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_POP_REAR   = 3'd4,
		REQ_COUNT      = 3'd5
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POPD,
		ST_LIST
	} state_t;

endpackage

@@ src/double_ended_queue.sv @@
// Push, count and refused/empty requests load the output register on acceptance when it
// is free; a pop or a list first reads the store into rd_data_q and then loads the output
// register, and a list then gives one item per cycle while the output is free.
// Throughput: one push or count per cycle while the output is free; after a pop or a list
// the block holds in_stall until its last item is loaded into the output register.
// Reset clears head pointer, element count and control; the store is left undefined.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values in a ring store with one synchronous
// read port and one write port, a head pointer and an element count.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dq_pkg::REQ_W-1:0]            req_type,
	input  logic signed [dq_pkg::VALUE_W-1:0]   push_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dq_pkg::VALUE_W-1:0]   value,
	output logic [dq_pkg::STATUS_W-1:0]         status,
	output logic [dq_pkg::ECOUNT_W-1:0]         elem_count,
	output logic                                last
);
	import dq_pkg::*;

	localparam int AW = $clog2(DEPTH);      // store address width
	localparam int CW = $clog2(DEPTH + 1);  // element count width

	// Ring slot at a given offset from a base; base < DEPTH and off <= DEPTH,
	// so one compare and subtract wraps it.
	function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + (AW+1)'(off);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// Control state
	state_t               state_q, state_d;
	logic [AW-1:0]        head_q, head_d;
	logic [CW-1:0]        count_q, count_d;
	logic [CW-1:0]        idx_q, idx_d;     // next list offset to read
	logic                 out_valid_q;

	// Latched request, used when the output register was busy at acceptance
	logic [REQ_W-1:0]           req_type_q;
	logic signed [VALUE_W-1:0]  push_value_q;

	// Output register payload
	logic signed [VALUE_W-1:0]  value_q, value_d;
	status_t                    status_q, status_d;
	logic [ECOUNT_W-1:0]        ecount_q, ecount_d;
	logic                       last_q, last_d;

	// Store and its ports
	logic signed [VALUE_W-1:0]  store_q [DEPTH];
	logic signed [VALUE_W-1:0]  rd_data_q;
	logic                       rd_en, wr_en;
	logic [AW-1:0]              rd_addr, wr_addr;
	logic signed [VALUE_W-1:0]  wr_data;

	logic                 in_fire, go, out_free, out_load, imm;
	status_t              imm_status;
	logic [REQ_W-1:0]     cur_type;
	logic signed [VALUE_W-1:0] cur_value;
	logic                 empty, full;
	logic [AW-1:0]        head_dec;

	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;

	// In idle the request comes straight from the ports; in EXEC it was latched
	// because the output register was still occupied.
	assign cur_type  = (state_q == ST_IDLE) ? req_type : req_type_q;
	assign cur_value = (state_q == ST_IDLE) ? push_value : push_value_q;
	assign go        = (state_q == ST_IDLE && in_valid) || (state_q == ST_EXEC);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		idx_d      = idx_q;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		wr_en      = 1'b0;
		wr_addr    = head_q;
		wr_data    = cur_value;
		out_load   = 1'b0;
		value_d    = '0;
		status_d   = STAT_OK;
		last_d     = 1'b1;
		imm        = 1'b0;
		imm_status = STAT_OK;
		in_stall   = (state_q != ST_IDLE);

		unique case (state_q)
			ST_IDLE, ST_EXEC: begin
				if (go) begin
					unique case (cur_type)
						REQ_LIST: begin
							if (empty) begin
								imm        = 1'b1;
								imm_status = STAT_EMPTY;
							end else begin
								// fetch the front element, stream the rest from LIST
								rd_en   = 1'b1;
								rd_addr = head_q;
								idx_d   = CW'(1);
								state_d = ST_LIST;
							end
						end
						REQ_PUSH_FRONT: begin
							imm = 1'b1;
							if (full) begin
								imm_status = STAT_FULL;
							end else if (out_free) begin
								head_d  = head_dec;
								wr_en   = 1'b1;
								wr_addr = head_dec;
								count_d = count_q + 1'b1;
							end
						end
						REQ_PUSH_REAR: begin
							imm = 1'b1;
							if (full) begin
								imm_status = STAT_FULL;
							end else if (out_free) begin
								wr_en   = 1'b1;
								wr_addr = slot_at(head_q, count_q);
								count_d = count_q + 1'b1;
							end
						end
						REQ_POP_FRONT: begin
							if (empty) begin
								imm        = 1'b1;
								imm_status = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								head_d  = slot_at(head_q, CW'(1));
								count_d = count_q - 1'b1;
								state_d = ST_POPD;
							end
						end
						REQ_POP_REAR: begin
							if (empty) begin
								imm        = 1'b1;
								imm_status = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = slot_at(head_q, count_q - 1'b1);
								count_d = count_q - 1'b1;
								state_d = ST_POPD;
							end
						end
						REQ_COUNT: begin
							imm = 1'b1;
						end
						default: begin
							// unknown kind: drop without a result
						end
					endcase

					// Results that need no store read: load now, or hold in EXEC
					// until the output register frees up.
					if (imm) begin
						if (out_free) begin
							out_load = 1'b1;
							status_d = imm_status;
							state_d  = ST_IDLE;
						end else begin
							state_d = ST_EXEC;
						end
					end
				end
			end
			ST_POPD: begin
				// read data stays in rd_data_q until the output register frees
				if (out_free) begin
					out_load = 1'b1;
					value_d  = rd_data_q;
					state_d  = ST_IDLE;
				end
			end
			ST_LIST: begin
				if (out_free) begin
					out_load = 1'b1;
					value_d  = rd_data_q;
					last_d   = (idx_q == count_q);
					if (idx_q == count_q) begin
						state_d = ST_IDLE;
					end else begin
						// advance: fetch the next element while this one goes out
						rd_en   = 1'b1;
						rd_addr = slot_at(head_q, idx_q);
						idx_d   = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		ecount_d = ECOUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_q   <= req_type;
			push_value_q <= push_value;
		end
		if (out_load) begin
			value_q  <= value_d;
			status_q <= status_d;
			ecount_q <= ecount_d;
			last_q   <= last_d;
		end
	end

	// Ring store: one write port, one read port with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign status     = status_q;
	assign elem_count = ecount_q;
	assign last       = last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_list_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIST |-> (idx_q != '0 && idx_q <= count_q))
		else $error("list offset out of range");

	a_popd_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POPD && $past(state_q) != ST_POPD) |-> $past(rd_en))
		else $error("pop result without store read");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (out_load && (state_q == ST_IDLE || state_q == ST_EXEC)))
		else $error("store write outside a push result");

	a_not_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> status_q == STAT_OK)
		else $error("non-final item with error status");
`endif

endmodule

@@ bench/double_ended_queue_tb.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded deque. A directed table covers the
// empty and full boundaries, value extremes, head wrap and the ignored request
// codes. Random bursts follow that fill, drain and mix the store. Every
// accepted request is run through a shadow deque that queues the items the
// block must return, and each returned item is checked against the oldest one.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
	import dq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int RAND_ITEMS  = 180;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 400000;

	// Request codes the block must ignore.
	localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
		logic [ECOUNT_W-1:0]       elem_count;
		logic                      last;
	} result_t;

	typedef struct {
		logic [REQ_W-1:0]          code;
		logic signed [VALUE_W-1:0] data;
		int                        reps;
		bit                        typed;
		result_t                   exp;
	} stim_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [REQ_W-1:0]            req_type;
	logic signed [VALUE_W-1:0]   push_value;
	logic                        out_valid;
	logic                        out_stall;
	logic signed [VALUE_W-1:0]   value;
	logic [STATUS_W-1:0]         status;
	logic [ECOUNT_W-1:0]         elem_count;
	logic                        last;

	// Shadow deque state.
	logic signed [VALUE_W-1:0] shadow_ring [DEPTH];
	int                        shadow_head;
	int                        shadow_count;

	result_t   pending_results [$];
	stim_row_t directed_rows [$];

	int errors;
	int cycles;
	int counted;
	bit calm;      // suppress gaps and stalls on both sides
	bit hold_req;  // ask the receiver for one long hold-off

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.status     (status),
		.elem_count (elem_count),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("double_ended_queue test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic queue_result(input logic signed [VALUE_W-1:0] v, input status_t st,
			input logic lst);
		result_t r;
		r.value      = v;
		r.status     = st;
		r.elem_count = shadow_count[ECOUNT_W-1:0];
		r.last       = lst;
		pending_results.push_back(r);
	endtask

	// Advance the shadow deque by one request; queue its items when asked.
	task automatic apply_request(input logic [REQ_W-1:0] code,
			input logic signed [VALUE_W-1:0] v, input bit keep);
		int idx;
		logic signed [VALUE_W-1:0] popped;
		case (code)
			REQ_LIST: begin
				if (shadow_count == 0) begin
					if (keep) queue_result('0, STAT_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						idx = (shadow_head + i) % DEPTH;
						if (keep) queue_result(shadow_ring[idx], STAT_OK, i == shadow_count - 1);
					end
				end
			end
			REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
				if (shadow_count >= DEPTH) begin
					if (keep) queue_result('0, STAT_FULL, 1'b1);
				end else begin
					if (code == REQ_PUSH_FRONT) begin
						shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
						shadow_ring[shadow_head] = v;
					end else begin
						shadow_ring[(shadow_head + shadow_count) % DEPTH] = v;
					end
					shadow_count++;
					if (keep) queue_result('0, STAT_OK, 1'b1);
				end
			end
			REQ_POP_FRONT, REQ_POP_REAR: begin
				if (shadow_count == 0) begin
					if (keep) queue_result('0, STAT_EMPTY, 1'b1);
				end else begin
					if (code == REQ_POP_FRONT) begin
						popped = shadow_ring[shadow_head];
						shadow_head = (shadow_head + 1) % DEPTH;
					end else begin
						popped = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
					end
					shadow_count--;
					if (keep) queue_result(popped, STAT_OK, 1'b1);
				end
			end
			REQ_COUNT: begin
				if (keep) queue_result('0, STAT_OK, 1'b1);
			end
			default: begin
				// drop: reserved codes leave the deque untouched
			end
		endcase
	endtask

	// Present one item at the falling edge and hold it until accepted.
	task automatic send_item(input logic [REQ_W-1:0] code, input logic signed [VALUE_W-1:0] v,
			input bit typed, input result_t texp);
		@(negedge clk);
		in_valid   = 1'b1;
		req_type   = code;
		push_value = v;
		do @(posedge clk); while (in_stall);
		apply_request(code, v, !typed);
		if (typed) pending_results.push_back(texp);
		if (code <= REQ_COUNT) counted++;
	endtask

	task automatic idle_for(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Bias the request mix by burst flavor: 0 fill, 1 drain, 2 mixed.
	function automatic logic [REQ_W-1:0] pick_request(input int flavor);
		int r;
		int push_pct;
		int pop_pct;
		r = $urandom_range(0, 99);
		push_pct = (flavor == 0) ? 75 : (flavor == 1) ? 15 : 40;
		pop_pct  = (flavor == 0) ? 10 : (flavor == 1) ? 70 : 40;
		if (r < 3) return ($urandom_range(0, 1) != 0) ? REQ_RSVD_A : REQ_RSVD_B;
		if (r < 3 + push_pct)
			return ($urandom_range(0, 1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
		if (r < 3 + push_pct + pop_pct)
			return ($urandom_range(0, 1) != 0) ? REQ_POP_FRONT : REQ_POP_REAR;
		if (r < 92) return REQ_COUNT;
		return REQ_LIST;
	endfunction

	task automatic add_row(input logic [REQ_W-1:0] code, input logic signed [VALUE_W-1:0] data,
			input int reps, input bit typed, input logic signed [VALUE_W-1:0] ev,
			input status_t es, input int ec);
		stim_row_t row;
		row.code             = code;
		row.data             = data;
		row.reps             = reps;
		row.typed            = typed;
		row.exp.value        = ev;
		row.exp.status       = es;
		row.exp.elem_count   = ec[ECOUNT_W-1:0];
		row.exp.last         = 1'b1;
		directed_rows.push_back(row);
	endtask

	// Check each returned item against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected item value=%0d status=%0d count=%0d",
					value, status, elem_count));
			end else begin
				e = pending_results.pop_front();
				if (value !== e.value)
					report_mismatch($sformatf("value %0d, want %0d", value, e.value));
				if (status !== e.status)
					report_mismatch($sformatf("status %0d, want %0d", status, e.status));
				if (elem_count !== e.elem_count)
					report_mismatch($sformatf("elem_count %0d, want %0d",
						elem_count, e.elem_count));
				if (last !== e.last)
					report_mismatch($sformatf("last %0b, want %0b", last, e.last));
			end
		end
	end

	// Receiver: random stalls at the falling edge, plus one long hold-off on request.
	initial begin
		int stall_left;
		int r;
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_stall = 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (calm) begin
				out_stall = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_stall = 1'b0;
				end else begin
					out_stall  = 1'b1;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
				end
			end
		end
	end

	// Sender and sequencing.
	initial begin
		result_t none;
		int      flavor;
		int      burst_len;
		int      bursts;
		logic [REQ_W-1:0] code;

		none         = '{value: '0, status: STAT_OK, elem_count: '0, last: 1'b0};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_COUNT;
		push_value   = '0;
		errors       = 0;
		cycles       = 0;
		counted      = 0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		shadow_head  = 0;
		shadow_count = 0;
		foreach (shadow_ring[i]) shadow_ring[i] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: typed rows check the empty/full boundaries and extremes,
		// the rest fall back on the shadow deque.
		add_row(REQ_COUNT,      '0,            1,  1, '0,            STAT_OK,    0);
		add_row(REQ_LIST,       '0,            1,  1, '0,            STAT_EMPTY, 0);
		add_row(REQ_POP_FRONT,  '0,            1,  1, '0,            STAT_EMPTY, 0);
		add_row(REQ_POP_REAR,   '0,            1,  1, '0,            STAT_EMPTY, 0);
		add_row(REQ_PUSH_FRONT, 32'sh7fff_ffff, 1, 1, '0,            STAT_OK,    1);
		add_row(REQ_PUSH_REAR,  32'sh8000_0000, 1, 1, '0,            STAT_OK,    2);
		add_row(REQ_LIST,       '0,            1,  0, '0,            STAT_OK,    0);
		add_row(REQ_POP_FRONT,  '0,            1,  1, 32'sh7fff_ffff, STAT_OK,   1);
		add_row(REQ_POP_REAR,   '0,            1,  1, 32'sh8000_0000, STAT_OK,   0);
		add_row(REQ_RSVD_A,     '1,            1,  0, '0,            STAT_OK,    0);
		add_row(REQ_RSVD_B,     '1,            1,  0, '0,            STAT_OK,    0);
		add_row(REQ_PUSH_FRONT, '1,            1,  1, '0,            STAT_OK,    1);
		add_row(REQ_PUSH_REAR,  '0,            1,  1, '0,            STAT_OK,    2);
		add_row(REQ_PUSH_FRONT, '0,            14, 0, '0,            STAT_OK,    0);
		add_row(REQ_PUSH_REAR,  32'sd5,        1,  1, '0,            STAT_FULL,  16);
		add_row(REQ_PUSH_FRONT, 32'sd5,        1,  1, '0,            STAT_FULL,  16);
		add_row(REQ_COUNT,      '0,            1,  1, '0,            STAT_OK,    16);
		add_row(REQ_LIST,       '0,            1,  0, '0,            STAT_OK,    0);
		add_row(REQ_POP_REAR,   '0,            16, 0, '0,            STAT_OK,    0);
		add_row(REQ_POP_FRONT,  '0,            1,  1, '0,            STAT_EMPTY, 0);

		foreach (directed_rows[i]) begin
			for (int k = 0; k < directed_rows[i].reps; k++) begin
				send_item(directed_rows[i].code,
					(directed_rows[i].reps > 1) ? $urandom : directed_rows[i].data,
					directed_rows[i].typed, directed_rows[i].exp);
				idle_for(rand_gap());
			end
		end
		idle_for(1);
		wait_drained();

		// Random bursts until enough real requests have gone in.
		bursts  = 0;
		while (counted < RAND_ITEMS) begin
			flavor    = $urandom_range(0, 2);
			burst_len = $urandom_range(8, 24);
			calm      = ($urandom_range(0, 4) == 0);
			if (bursts == 2) begin
				// Hold the output off and keep offering items so the block backs up.
				calm     = 1'b1;
				hold_req = 1'b1;
				for (int k = 0; k < 24; k++) begin
					code = ($urandom_range(0, 3) == 0) ? REQ_COUNT : REQ_PUSH_REAR;
					send_item(code, pick_value(), 0, none);
				end
				calm = 1'b0;
				idle_for(1);
				wait_drained();
			end else begin
				for (int k = 0; k < burst_len; k++) begin
					send_item(pick_request(flavor), pick_value(), 0, none);
					idle_for(rand_gap());
				end
				// Pause the sender now and then until the output side catches up.
				if ($urandom_range(0, 3) == 0) begin
					idle_for(1);
					wait_drained();
				end
			end
			bursts++;
		end
		calm = 1'b0;
		idle_for(1);

		// Drain, then give stray items time to show up.
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("double_ended_queue test passed");
		end else begin
			$display("double_ended_queue test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/dq_pkg.sv
src/double_ended_queue.sv
bench/double_ended_queue_tb.sv
